@@ rtl/core/pspwm_pkg.sv @@
package pspwm_pkg;

  // Fixed-point format of the speeds and PWM range
  localparam int SPEED_FRAC_BITS = 8;
  localparam int PWM_MAX         = 255;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int MAG_W   = SPEED_W + 1;  // magnitude of a speed, up to 32768
  localparam int ERR_W   = 17;           // error and integral state
  localparam int ACC_W   = ERR_W + 1;    // integral before clamping
  localparam int DER_W   = ERR_W + 1;    // error change
  localparam int GAIN_W  = 11;
  localparam int LIMIT_W = 15;
  localparam int DUTY_W  = 8;

  // Product and sum widths
  localparam int PROD_E_W = GAIN_W + ERR_W;
  localparam int PROD_D_W = GAIN_W + DER_W;
  localparam int SUM_W    = PROD_D_W + 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd25600;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic        [LIMIT_W-1:0] limit;
  } cfg_t;

  // Error terms after the integral update
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] integ;
    logic signed [DER_W-1:0] deriv;
  } terms_t;

  // Weighted terms
  typedef struct packed {
    logic signed [PROD_E_W-1:0] prop;
    logic signed [PROD_E_W-1:0] integ;
    logic signed [PROD_D_W-1:0] deriv;
  } prods_t;

endpackage

@@ rtl/core/pspwm_regs.sv @@
module pspwm_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pspwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pspwm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pspwm_pkg::cfg_t                     cfg
);
  import pspwm_pkg::*;

  // Decode writes into the gain and limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p <= '0;
      cfg.gain_i <= '0;
      cfg.gain_d <= '0;
      cfg.limit  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:    cfg.gain_p <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_I:    cfg.gain_i <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_D:    cfg.gain_d <= $signed(cfg_data[GAIN_W-1:0]);
        REG_INT_LIMIT: cfg.limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/pspwm_integ.sv @@
module pspwm_integ (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pspwm_pkg::cfg_t                       cfg,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pspwm_pkg::SPEED_W-1:0]  target_speed,
  input  logic signed [pspwm_pkg::SPEED_W-1:0]  measured_speed,
  output logic                                  dn_valid,
  input  logic                                  dn_space,
  output pspwm_pkg::terms_t                     dn_terms
);
  import pspwm_pkg::*;

  logic                      valid0;
  logic signed [SPEED_W-1:0] target_q;
  logic signed [SPEED_W-1:0] measured_q;
  logic                      space0;
  logic                      space1;
  logic                      fire1;

  logic signed [ERR_W-1:0]   error_sum;
  logic signed [ERR_W-1:0]   previous_error;
  logic signed [ERR_W-1:0]   error_sum_next;

  logic [MAG_W-1:0]          t_mag;
  logic [MAG_W-1:0]          m_mag;
  logic signed [ERR_W-1:0]   err;
  logic                      hold;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   lim;
  logic signed [DER_W-1:0]   deriv;

  // Stage handshake: a stage loads when empty or when its word moves on
  assign space1   = !dn_valid || dn_space;
  assign space0   = !valid0 || space1;
  assign fire1    = valid0 && space1;
  assign in_stall = !space0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else if (space0) begin
      valid0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space0 && in_valid) begin
      target_q   <= target_speed;
      measured_q <= measured_speed;
    end
  end

  // Magnitudes and error
  always_comb begin
    t_mag = target_q[SPEED_W-1]   ? MAG_W'(-$signed({target_q[SPEED_W-1], target_q}))
                                  : {1'b0, target_q};
    m_mag = measured_q[SPEED_W-1] ? MAG_W'(-$signed({measured_q[SPEED_W-1], measured_q}))
                                  : {1'b0, measured_q};
    err   = $signed(t_mag) - $signed(m_mag);
    // Motor stalled against a nonzero target: hold the integral
    hold  = (t_mag != '0) && (m_mag == '0);
  end

  // Integral update and clamp
  always_comb begin
    lim = $signed({{(ACC_W-LIMIT_W){1'b0}}, cfg.limit});
    acc = {error_sum[ERR_W-1], error_sum};
    if (!hold) begin
      acc = acc + {err[ERR_W-1], err};
    end
    if (acc > lim) begin
      acc = lim;
    end else if (acc < -lim) begin
      acc = -lim;
    end
    error_sum_next = acc[ERR_W-1:0];
    deriv = {err[ERR_W-1], err} - {previous_error[ERR_W-1], previous_error};
  end

  // Controller state advances once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (fire1) begin
      error_sum      <= error_sum_next;
      previous_error <= err;
    end
  end

  // Terms register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (space1) begin
      dn_valid <= valid0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      dn_terms.err   <= err;
      dn_terms.integ <= error_sum_next;
      dn_terms.deriv <= deriv;
    end
  end

  // The integral sits inside the clamp after each word
  a_integ_clamped: assert property (@(posedge clk) disable iff (rst)
    fire1 |=> (error_sum <= $signed({2'b00, $past(cfg.limit)})) &&
              (error_sum >= -$signed({2'b00, $past(cfg.limit)})))
    else $error("integral outside clamp");

  // The previous error tracks the word just processed
  a_prev_err: assert property (@(posedge clk) disable iff (rst)
    fire1 |=> previous_error == dn_terms.err)
    else $error("previous error out of step");

  // An empty input register never stalls the source
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !valid0 |-> !in_stall)
    else $error("stall while input register empty");

endmodule

@@ rtl/core/pspwm_mult.sv @@
module pspwm_mult (
  input  logic               clk,
  input  logic               rst,
  input  pspwm_pkg::cfg_t    cfg,
  input  logic               up_valid,
  output logic               up_space,
  input  pspwm_pkg::terms_t  up_terms,
  output logic               dn_valid,
  input  logic               dn_space,
  output pspwm_pkg::prods_t  dn_prods
);
  import pspwm_pkg::*;

  logic load;

  assign up_space = !dn_valid || dn_space;
  assign load     = up_valid && up_space;

  // Hold the valid flag until the word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_space) begin
      dn_valid <= up_valid;
    end
  end

  // Weight each term by its gain
  always_ff @(posedge clk) begin
    if (load) begin
      dn_prods.prop  <= PROD_E_W'(cfg.gain_p * up_terms.err);
      dn_prods.integ <= PROD_E_W'(cfg.gain_i * up_terms.integ);
      dn_prods.deriv <= PROD_D_W'(cfg.gain_d * up_terms.deriv);
    end
  end

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> dn_valid)
    else $error("loaded word not marked valid");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_space |=> dn_valid && $stable(dn_prods))
    else $error("waiting products changed");

  a_empty_space: assert property (@(posedge clk) disable iff (rst)
    !dn_valid |-> up_space)
    else $error("empty product stage refused a word");

endmodule

@@ rtl/core/pspwm_out.sv @@
module pspwm_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                up_valid,
  output logic                                up_space,
  input  pspwm_pkg::prods_t                   up_prods,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pspwm_pkg::DUTY_W-1:0]        pwm_duty
);
  import pspwm_pkg::*;

  logic                    load;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shifted;
  logic [DUTY_W-1:0]       duty_next;

  localparam logic signed [SUM_W-1:0] PWM_MAX_S = SUM_W'(PWM_MAX);

  assign up_space = !out_valid || !out_stall;
  assign load     = up_valid && up_space;

  // Add the terms, drop the fraction, saturate into the PWM range
  always_comb begin
    sum = SUM_W'(up_prods.prop) + SUM_W'(up_prods.integ) + SUM_W'(up_prods.deriv);
    shifted = sum >>> SPEED_FRAC_BITS;
    if (sum <= 0) begin
      duty_next = '0;
    end else if (shifted > PWM_MAX_S) begin
      duty_next = PWM_MAX_S[DUTY_W-1:0];
    end else begin
      duty_next = shifted[DUTY_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_space) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pwm_duty <= duty_next;
    end
  end

  a_neg_zero: assert property (@(posedge clk) disable iff (rst)
    load && (sum <= 0) |=> pwm_duty == '0)
    else $error("nonpositive sum gave nonzero duty");

  a_saturate: assert property (@(posedge clk) disable iff (rst)
    load && (shifted >= PWM_MAX_S) |=> pwm_duty == PWM_MAX_S[DUTY_W-1:0])
    else $error("large sum not saturated");

  a_empty_space: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> up_space)
    else $error("empty output register refused a word");

endmodule

@@ rtl/core/pid_speed_to_pwm_core.sv @@
// PID speed controller that turns a target and a measured speed (signed Q8.8,
// sign ignored) into an 8-bit motor PWM duty, one duty word per input word.
// The integral is held while the motor stands still against a nonzero target
// and is clamped to +/- integral_limit. A new word is accepted every clock
// cycle while in_stall is low; each word passes through the input register,
// the integral/derivative stage, the gain multiply stage and the output
// register, and the duty waits in the output register while out_stall is
// high. The integral add-and-clamp loop sets this rate. Gains and the limit
// are written through the cfg_we/cfg_index/cfg_data port while no word is in
// flight; index 0..3 selects proportional gain, integral gain, derivative
// gain and integral limit.
module pid_speed_to_pwm_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pspwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pspwm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pspwm_pkg::SPEED_W-1:0] target_speed,
  input  logic signed [pspwm_pkg::SPEED_W-1:0] measured_speed,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pspwm_pkg::DUTY_W-1:0]         pwm_duty
);
  import pspwm_pkg::*;

  cfg_t   cfg;
  logic   terms_valid;
  logic   terms_space;
  terms_t terms;
  logic   prods_valid;
  logic   prods_space;
  prods_t prods;

  // Gain and limit registers
  pspwm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Error, integral and derivative
  pspwm_integ u_integ (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .dn_valid       (terms_valid),
    .dn_space       (terms_space),
    .dn_terms       (terms)
  );

  // Gain multiplies
  pspwm_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (terms_valid),
    .up_space (terms_space),
    .up_terms (terms),
    .dn_valid (prods_valid),
    .dn_space (prods_space),
    .dn_prods (prods)
  );

  // Sum, scale and saturate
  pspwm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (prods_valid),
    .up_space  (prods_space),
    .up_prods  (prods),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pwm_duty  (pwm_duty)
  );

endmodule
